### sv/docit_pkg.sv
// Shared types, constants and helpers of the damped orbit camera integrator.
package docit_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_KEY_MAP        = 3'd0,
        REG_SPEED_GAINS    = 3'd1,
        REG_ACCEL_GAINS    = 3'd2,
        REG_DAMPING_GAINS  = 3'd3,
        REG_RADIUS_FLOOR   = 3'd4,
        REG_RADIUS_CEILING = 3'd5,
        REG_ENABLED        = 3'd6
    } reg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int NUM_KEYS   = 6;

    // Inclination bounds and reset value, signed Q16.16.
    localparam logic signed [31:0] INC_LOW   = -32'sd205232;
    localparam logic signed [31:0] INC_HIGH  = -32'sd655;
    localparam logic signed [31:0] INC_RESET = -32'sd102944;

    typedef struct packed {
        logic [47:0] key_map;
        logic [47:0] speed_gains;
        logic [47:0] accel_gains;
        logic [47:0] damping_gains;
        logic [31:0] radius_floor;
        logic [31:0] radius_ceiling;
        logic        enabled;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
        logic       pressed;
    } key_evt_t;

    // Command for the shared multiply-accumulate unit.
    typedef struct packed {
        logic clr;   // start a new sum instead of adding to the old one
        logic sh17;  // weight the product by 2^17
    } mac_cmd_t;

    // Steps of the per-axis sequence, in order.
    typedef enum logic [2:0] {
        OP_STEP  = 3'd0,
        OP_DAMP  = 3'd1,
        OP_VLO   = 3'd2,
        OP_VHI   = 3'd3,
        OP_SPEED = 3'd4,
        OP_DLO   = 3'd5,
        OP_DHI   = 3'd6
    } op_t;

    // Picks the 16-bit gain of one axis out of a packed gain register.
    function automatic logic [15:0] pick16(input logic [47:0] v, input logic [1:0] k);
        logic [15:0] r;
        case (k)
            2'd0:    r = v[15:0];
            2'd1:    r = v[31:16];
            2'd2:    r = v[47:32];
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

### sv/damped_orbit_camera_integrator_unit.sv
// Orbit camera integrator: key flags, per-axis damped velocity and clamped position.
//
// Input words arrive on s_tvalid/s_tready. s_tuser says whether the word is a key event
// or a time tick; every accepted word gives exactly one output word on m_tvalid/m_tready
// holding the current azimuth, inclination and radius.
// A key event or a tick while disabled goes from idle straight to the done state, which
// loads the output register and raises m_tvalid; the sequencer then returns to idle.
// An enabled tick runs the three axes in turn through seven multiply steps each on one
// shared 32x17 multiplier with an accumulator, a step passing through a multiply, an
// accumulate and a use of the sum, except the low halves of the two wide products, which
// skip the last of the three; an update step then writes the positions before done.
// s_tready is high only while the sequencer is idle, so one word is in work at a time.
// The result sits in an output register; if the receiver stalls, the finished word
// waits there and the sequencer holds until the register is free.
// Configuration writes on cfg_valid/cfg_ready are taken every cycle and must be made
// only while no word is in work.
// Reset clears the key flags and velocities, sets azimuth and radius to zero and the
// inclination to minus pi over two, and loads the register defaults (ceiling all ones,
// block enabled). The radius is clamped to its bounds on the first enabled tick.
module damped_orbit_camera_integrator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // key_id, pressed, time_delta, zero pad
    input  logic [0:0]                       s_tuser,   // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [95:0]                      m_tdata,   // azimuth, inclination, distance
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [docit_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [docit_pkg::CFG_DATA_W-1:0] cfg_data
);
    import docit_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ISSUE  = 6'b000010,
        ST_ACCUM  = 6'b000100,
        ST_POST   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    cfg_t                cfg;
    logic [NUM_KEYS-1:0] key_flags;
    key_evt_t            key_evt;

    logic [1:0]  axis_reg;
    op_t         op_reg;
    logic [15:0] dt_reg;

    logic [31:0] w_mag_reg;
    logic        w_neg_reg;
    logic [32:0] f_reg;
    logic [31:0] vmag_reg;
    logic [31:0] s_reg;

    logic signed [31:0] vel_reg [3];
    logic signed [40:0] delta_reg [3];

    logic [31:0]        pos_az_reg;
    logic signed [31:0] pos_inc_reg;
    logic [31:0]        pos_rad_reg;

    logic [95:0] out_data_reg;
    logic        m_tvalid_reg;

    logic        in_kind;
    logic        accept;
    logic        out_load;

    mac_cmd_t    mac_cmd;
    logic [31:0] mac_a;
    logic [16:0] mac_b;
    logic [63:0] acc;
    logic        mac_issue;

    logic [15:0] accel_g;
    logic [15:0] damp_g;
    logic [15:0] speed_g;
    logic signed [31:0] vel_cur;
    logic        inc_key;
    logic        dec_key;
    logic [23:0] step;
    logic [33:0] w_ext;
    logic [33:0] step_ext;
    logic [33:0] w_sum;
    logic [31:0] w_sat;
    logic [31:0] w_mag;
    logic [32:0] f_val;
    logic [63:0] vround;
    logic [31:0] vmag;
    logic [31:0] vnew;
    logic [63:0] dround;
    logic [40:0] dext;
    logic [40:0] dnew;

    logic signed [41:0] r_sum;
    logic signed [41:0] r_cap;
    logic signed [41:0] ceil_ext;
    logic signed [41:0] floor_ext;
    logic [31:0]        r_fin;
    logic signed [41:0] c_sum;
    logic signed [31:0] c_fin;
    logic [31:0]        az_fin;

    docit_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_evt   (key_evt),
        .cfg       (cfg),
        .key_flags (key_flags)
    );

    docit_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (mac_issue),
        .cmd   (mac_cmd),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .acc   (acc)
    );

    assign in_kind  = s_tuser[0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        key_evt.valid   = accept && !in_kind;
        key_evt.code    = s_tdata[7:0];
        key_evt.pressed = s_tdata[8];
    end

    // Per-axis operands.
    always_comb
    begin
        accel_g = pick16(cfg.accel_gains, axis_reg);
        damp_g  = pick16(cfg.damping_gains, axis_reg);
        speed_g = pick16(cfg.speed_gains, axis_reg);
        vel_cur = vel_reg[axis_reg];
        inc_key = key_flags[{axis_reg, 1'b0}];
        dec_key = key_flags[{axis_reg, 1'b1}];
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mac_cmd.clr  = 1'b1;
        mac_cmd.sh17 = 1'b0;
        mac_a        = 32'd0;
        mac_b        = 17'd0;
        case (op_reg)
            OP_STEP:
            begin
                mac_a = {16'd0, accel_g};
                mac_b = {1'b0, dt_reg};
            end
            OP_DAMP:
            begin
                mac_a = {15'd0, 17'h1_0000 - {1'b0, damp_g}};
                mac_b = {1'b0, dt_reg};
            end
            OP_VLO:
            begin
                mac_a = w_mag_reg;
                mac_b = f_reg[16:0];
            end
            OP_VHI:
            begin
                mac_a        = w_mag_reg;
                mac_b        = {1'b0, f_reg[32:17]};
                mac_cmd.clr  = 1'b0;
                mac_cmd.sh17 = 1'b1;
            end
            OP_SPEED:
            begin
                mac_a = {16'd0, speed_g};
                mac_b = {1'b0, dt_reg};
            end
            OP_DLO:
            begin
                mac_a = vmag_reg;
                mac_b = s_reg[16:0];
            end
            OP_DHI:
            begin
                mac_a        = vmag_reg;
                mac_b        = {2'd0, s_reg[31:17]};
                mac_cmd.clr  = 1'b0;
                mac_cmd.sh17 = 1'b1;
            end
            default:
            begin
                mac_a = 32'd0;
            end
        endcase
    end

    // Work on the finished sum of each step.
    always_comb
    begin
        step     = acc[31:8];
        w_ext    = {{2{vel_cur[31]}}, vel_cur};
        step_ext = {10'd0, step};
        // Increase key pulls the velocity down, decrease key pushes it up.
        if (inc_key && !dec_key)
        begin
            w_sum = w_ext - step_ext;
        end
        else if (dec_key && !inc_key)
        begin
            w_sum = w_ext + step_ext;
        end
        else
        begin
            w_sum = w_ext;
        end
        if ((w_sum[33:31] == 3'b000) || (w_sum[33:31] == 3'b111))
        begin
            w_sat = w_sum[31:0];
        end
        else
        begin
            w_sat = w_sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        w_mag  = w_sat[31] ? (~w_sat + 32'd1) : w_sat;
        f_val  = 33'h1_0000_0000 - acc[32:0];
        // Magnitudes are rounded half up, then the sign is put back.
        vround = acc + 64'h0000_0000_8000_0000;
        vmag   = vround[63:32];
        vnew   = w_neg_reg ? (~vmag + 32'd1) : vmag;
        dround = acc + 64'h0000_0000_0080_0000;
        dext   = {1'b0, dround[63:24]};
        dnew   = w_neg_reg ? (~dext + 41'd1) : dext;
    end

    // New positions from the three deltas.
    always_comb
    begin
        ceil_ext  = $signed({10'd0, cfg.radius_ceiling});
        floor_ext = $signed({10'd0, cfg.radius_floor});
        r_sum     = $signed({10'd0, pos_rad_reg}) + 42'(delta_reg[2]);
        r_cap     = (r_sum > ceil_ext) ? ceil_ext : r_sum;
        r_fin     = (r_cap < floor_ext) ? cfg.radius_floor : r_cap[31:0];
        c_sum     = 42'(pos_inc_reg) + 42'(delta_reg[1]);
        if (c_sum > 42'(INC_HIGH))
        begin
            c_fin = INC_HIGH;
        end
        else if (c_sum < 42'(INC_LOW))
        begin
            c_fin = INC_LOW;
        end
        else
        begin
            c_fin = c_sum[31:0];
        end
        az_fin = pos_az_reg + delta_reg[0][31:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        mac_issue  = (state_reg == ST_ISSUE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (in_kind && cfg.enabled) ? ST_ISSUE : ST_DONE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                // The low partial products skip the post step.
                if ((op_reg == OP_VLO) || (op_reg == OP_DLO))
                begin
                    state_next = ST_ISSUE;
                end
                else
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                if ((op_reg == OP_DHI) && (axis_reg == 2'd2))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            axis_reg     <= 2'd0;
            op_reg       <= OP_STEP;
            m_tvalid_reg <= 1'b0;
            vel_reg[0]   <= 32'sd0;
            vel_reg[1]   <= 32'sd0;
            vel_reg[2]   <= 32'sd0;
            pos_az_reg   <= 32'd0;
            pos_inc_reg  <= INC_RESET;
            pos_rad_reg  <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                axis_reg <= 2'd0;
                op_reg   <= OP_STEP;
            end
            if ((state_reg == ST_ACCUM) && ((op_reg == OP_VLO) || (op_reg == OP_DLO)))
            begin
                op_reg <= op_t'(op_reg + 3'd1);
            end
            if (state_reg == ST_POST)
            begin
                if (op_reg == OP_DHI)
                begin
                    if (axis_reg != 2'd2)
                    begin
                        axis_reg <= axis_reg + 2'd1;
                        op_reg   <= OP_STEP;
                    end
                end
                else
                begin
                    op_reg <= op_t'(op_reg + 3'd1);
                end
                if (op_reg == OP_VHI)
                begin
                    vel_reg[axis_reg] <= vnew;
                end
            end
            if (state_reg == ST_UPDATE)
            begin
                pos_az_reg  <= az_fin;
                pos_inc_reg <= c_fin;
                pos_rad_reg <= r_fin;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dt_reg <= s_tdata[24:9];
        end
        if (state_reg == ST_POST)
        begin
            case (op_reg)
                OP_STEP:
                begin
                    w_mag_reg <= w_mag;
                    w_neg_reg <= w_sat[31];
                end
                OP_DAMP:  f_reg    <= f_val;
                OP_VHI:   vmag_reg <= vmag;
                OP_SPEED: s_reg    <= acc[31:0];
                OP_DHI:   delta_reg[axis_reg] <= dnew;
                default:  ;
            endcase
        end
        if (out_load)
        begin
            out_data_reg <= {pos_rad_reg, pos_inc_reg, pos_az_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_inc_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_inc_reg >= INC_LOW) && (pos_inc_reg <= INC_HIGH))
        else $error("inclination left its bounds");

    a_rad_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> (pos_rad_reg >= cfg.radius_floor))
        else $error("radius below floor after update");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("output word raised outside the done state");

    a_post_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POST) |-> ((op_reg != OP_VLO) && (op_reg != OP_DLO)
                                    && (axis_reg != 2'd3)))
        else $error("sequencer reached a post step it must skip");
`endif

endmodule

### sv/docit_mac.sv
// Shared 32x17 multiplier with a registered product and a 64-bit accumulator.
module docit_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue,
    input  docit_pkg::mac_cmd_t cmd,
    input  logic [31:0]         op_a,
    input  logic [16:0]         op_b,
    output logic [63:0]         acc
);
    import docit_pkg::*;

    logic [48:0] prod_reg;
    mac_cmd_t    cmd_reg;
    logic        go_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg <= 1'b0;
        end
        else
        begin
            go_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= op_a * op_b;
            cmd_reg  <= cmd;
        end
        if (go_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        addend   = cmd_reg.sh17 ? {prod_reg[46:0], 17'd0} : {15'd0, prod_reg};
        acc_next = (cmd_reg.clr ? 64'd0 : acc_reg) + addend;
    end

    assign acc = acc_reg;

endmodule

### sv/docit_regs.sv
// Configuration registers and pressed-key flags.
module docit_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [docit_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [docit_pkg::CFG_DATA_W-1:0] cfg_data,
    input  docit_pkg::key_evt_t           key_evt,
    output docit_pkg::cfg_t               cfg,
    output logic [docit_pkg::NUM_KEYS-1:0] key_flags
);
    import docit_pkg::*;

    cfg_t                cfg_reg;
    logic [NUM_KEYS-1:0] flags_reg;
    logic [NUM_KEYS-1:0] flags_next;
    logic [7:0]          mapped;

    assign cfg_ready = 1'b1;

    // A key code of zero is unmapped; every matching slot takes the new state.
    always_comb
    begin
        flags_next = flags_reg;
        mapped     = 8'd0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            mapped = cfg_reg.key_map[8*i +: 8];
            if (key_evt.valid && (mapped != 8'd0) && (mapped == key_evt.code))
            begin
                flags_next[i] = key_evt.pressed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_map        <= 48'd0;
            cfg_reg.speed_gains    <= 48'd0;
            cfg_reg.accel_gains    <= 48'd0;
            cfg_reg.damping_gains  <= 48'd0;
            cfg_reg.radius_floor   <= 32'd0;
            cfg_reg.radius_ceiling <= 32'hFFFF_FFFF;
            cfg_reg.enabled        <= 1'b1;
            flags_reg              <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_KEY_MAP:        cfg_reg.key_map        <= cfg_data;
                    REG_SPEED_GAINS:    cfg_reg.speed_gains    <= cfg_data;
                    REG_ACCEL_GAINS:    cfg_reg.accel_gains    <= cfg_data;
                    REG_DAMPING_GAINS:  cfg_reg.damping_gains  <= cfg_data;
                    REG_RADIUS_FLOOR:   cfg_reg.radius_floor   <= cfg_data[31:0];
                    REG_RADIUS_CEILING: cfg_reg.radius_ceiling <= cfg_data[31:0];
                    REG_ENABLED:        cfg_reg.enabled        <= cfg_data[0];
                    default:            ;
                endcase
            end
        end
    end

    assign cfg       = cfg_reg;
    assign key_flags = flags_reg;

endmodule
